// ===== hw/rtl/pfla_pkg.sv =====
// ----------------------------------------------------------------------------
// pfla_pkg
// Shared types and constants for the page free list allocator: command and
// status codes, configuration register indexes and the item structs.
// ----------------------------------------------------------------------------
package pfla_pkg;

  // byte address width of managed physical memory
  localparam int AW = 39;
  // width of the free count field of a result
  localparam int FCW = 16;

  // command codes, code 3 is unused and returns an OK result with no change
  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_BAD_FREE = 2'd2,
    STAT_OVERFLOW = 2'd3
  } status_t;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KERNEL_END = 1'b0;
  localparam cfg_idx_t CFG_MEMORY_TOP = 1'b1;

  // input item
  typedef struct packed {
    logic [1:0]    command;
    logic [AW-1:0] page_address;
  } in_item_t;

  // result item
  typedef struct packed {
    logic [AW-1:0]  allocated_address;
    logic [1:0]     status;
    logic [FCW-1:0] free_count;
  } out_item_t;

endpackage

// ===== hw/rtl/pfla_link_mem.sv =====
// ----------------------------------------------------------------------------
// pfla_link_mem
// Next-link memory of the free list: one write port and one read port,
// read data registered, no reset of the contents.
// ----------------------------------------------------------------------------
module pfla_link_mem #(
  parameter int DEPTH = 32768,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [AddrW-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [AddrW-1:0] rdata
);

  logic [AddrW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered, holds data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/pfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfla_ctrl
// Command sequencer of the allocator: holds the list head and free count,
// drives the link memory, walks the page range on init and owns the
// result register with a one-entry hold for a stalled result.
// ----------------------------------------------------------------------------
module pfla_ctrl import pfla_pkg::*; #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12,
  localparam int SW = $clog2(MAX_PAGES),
  localparam int CW = $clog2(MAX_PAGES + 1)
) (
  input  logic          clk,
  input  logic          rst,
  // input channel
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data,
  // configuration values
  input  logic [AW:0]   base_addr,
  input  logic [AW-1:0] top_addr,
  // link memory
  output logic          mem_we,
  output logic [SW-1:0] mem_waddr,
  output logic [SW-1:0] mem_wdata,
  output logic          mem_re,
  output logic [SW-1:0] mem_raddr,
  input  logic [SW-1:0] mem_rdata
);

  localparam int PW = AW - PAGE_SHIFT;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK,
    ST_HOLD
  } state_t;

  state_t          state;
  in_item_t        item;
  logic [SW-1:0]   head;
  logic [CW-1:0]   count;
  logic [SW-1:0]   walk_idx;
  logic [SW-1:0]   walk_last;
  logic            walk_ovf;
  out_item_t       pend;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic [AW:0]     free_diff;
  logic            free_ok;
  logic [SW-1:0]   free_slot;
  logic [AW:0]     init_span;
  logic [PW-1:0]   init_pages;
  logic            init_ovf;
  logic [PW-1:0]   init_n;
  logic [SW-1:0]   init_last;
  logic [AW:0]     alloc_sum;
  logic            fin_valid;
  out_item_t       fin_data;
  logic            walk_start;
  logic [SW-1:0]   head_next;
  logic [CW-1:0]   count_next;

  // one item at a time, reads and writes never share a cycle
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // result register loads a finished or held result when it is free
  assign out_load = out_free && (fin_valid || (state == ST_HOLD));

  // the pop reads the link of the head as the item is taken
  assign mem_re    = accept;
  assign mem_raddr = head;

  // free address checks and slot
  assign free_diff = {1'b0, item.page_address} - base_addr;
  assign free_slot = free_diff[PAGE_SHIFT+SW-1:PAGE_SHIFT];
  assign free_ok   = (item.page_address[PAGE_SHIFT-1:0] == '0)
                  && ({1'b0, item.page_address} >= base_addr)
                  && (item.page_address < top_addr)
                  && (count < CW'(MAX_PAGES))
                  && (free_diff[AW-1:PAGE_SHIFT] < PW'(MAX_PAGES));

  // number of pages between base and top for init
  assign init_span  = {1'b0, top_addr} - base_addr;
  assign init_pages = ({1'b0, top_addr} >= base_addr) ? init_span[AW-1:PAGE_SHIFT] : '0;
  assign init_ovf   = init_pages > PW'(MAX_PAGES);
  assign init_n     = init_ovf ? PW'(MAX_PAGES) : init_pages;
  assign init_last  = SW'(init_n - PW'(1));

  // address of the popped page
  assign alloc_sum = base_addr + ((AW + 1)'(head) << PAGE_SHIFT);

  // command execution and result
  always_comb begin
    fin_valid  = 1'b0;
    walk_start = 1'b0;
    head_next  = head;
    count_next = count;
    mem_we     = 1'b0;
    mem_waddr  = free_slot;
    mem_wdata  = head;
    fin_data   = '0;
    fin_data.status = STAT_OK;
    unique case (state)
      ST_EXEC: begin
        unique case (item.command)
          CMD_INIT: begin
            if (init_n == '0) begin
              fin_valid  = 1'b1;
              head_next  = '0;
              count_next = '0;
            end else begin
              walk_start = 1'b1;
            end
          end
          CMD_ALLOC: begin
            fin_valid = 1'b1;
            if (count == '0) begin
              fin_data.status = STAT_EMPTY;
            end else begin
              fin_data.allocated_address = alloc_sum[AW-1:0];
              head_next  = mem_rdata;
              count_next = count - CW'(1);
            end
          end
          CMD_FREE: begin
            fin_valid = 1'b1;
            if (free_ok) begin
              mem_we     = 1'b1;
              head_next  = free_slot;
              count_next = count + CW'(1);
            end else begin
              fin_data.status = STAT_BAD_FREE;
            end
          end
          default: begin
            fin_valid = 1'b1;
          end
        endcase
      end
      ST_WALK: begin
        // push slots in ascending order, each links to the one below
        mem_we    = 1'b1;
        mem_waddr = walk_idx;
        mem_wdata = (walk_idx == '0) ? '0 : walk_idx - SW'(1);
        if (walk_idx == walk_last) begin
          fin_valid  = 1'b1;
          head_next  = walk_last;
          count_next = CW'(walk_last) + CW'(1);
          if (walk_ovf) begin
            fin_data.status = STAT_OVERFLOW;
          end
        end
      end
      default: ;
    endcase
    fin_data.free_count = FCW'(count_next);
  end

  // state, list registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            item  <= in_data;
            state <= ST_EXEC;
          end
        end
        ST_EXEC, ST_WALK: begin
          if (state == ST_WALK) begin
            walk_idx <= walk_idx + SW'(1);
          end
          if (walk_start) begin
            walk_idx  <= '0;
            walk_last <= init_last;
            walk_ovf  <= init_ovf;
            state     <= ST_WALK;
          end else if (fin_valid) begin
            if (out_free) begin
              out_data  <= fin_data;
              state     <= ST_IDLE;
            end else begin
              pend  <= fin_data;
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            out_data  <= pend;
            state     <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/page_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// page_free_list_allocator_top
// Physical page allocator with a LIFO free list kept in a next-link memory
// indexed by page slot, a head register and a free page counter.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_stall    in_data     (in_item_t)
//   out       output     out_valid / out_stall  out_data    (out_item_t)
//   cfg       input      cfg_wr_en              cfg_index, cfg_wr_data
//
// Allocate and free are a transfer, then one link memory access and the
// head update. Init does one link write per page in the walk. The link
// memory is not cleared at reset; only head, count, state, the result
// valid flag and the address registers are. A stalled result waits in the
// output register while the next item is taken; a second finished result
// then waits in a hold register until the first one transfers.
// ----------------------------------------------------------------------------
module page_free_list_allocator_top import pfla_pkg::*; #(
  parameter int MAX_PAGES  = 32768,
  parameter int PAGE_SHIFT = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_item_t      in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_item_t     out_data,
  input  logic          cfg_wr_en,
  input  cfg_idx_t      cfg_index,
  input  logic [AW-1:0] cfg_wr_data
);

  localparam int SW = $clog2(MAX_PAGES);
  localparam logic [AW:0] PAGE_MASK = (AW + 1)'((64'd1 << PAGE_SHIFT) - 64'd1);

  logic [AW:0]   base_addr;
  logic [AW-1:0] top_addr;
  logic          mem_we;
  logic [SW-1:0] mem_waddr;
  logic [SW-1:0] mem_wdata;
  logic          mem_re;
  logic [SW-1:0] mem_raddr;
  logic [SW-1:0] mem_rdata;

  // configuration registers, kernel end kept rounded up to a page
  always_ff @(posedge clk) begin
    if (rst) begin
      base_addr <= '0;
      top_addr  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KERNEL_END: base_addr <= ({1'b0, cfg_wr_data} + PAGE_MASK) & ~PAGE_MASK;
        CFG_MEMORY_TOP: top_addr  <= cfg_wr_data;
      endcase
    end
  end

  // command sequencer
  pfla_ctrl #(
    .MAX_PAGES  (MAX_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .base_addr (base_addr),
    .top_addr  (top_addr),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // next-link memory
  pfla_link_mem #(
    .DEPTH (MAX_PAGES)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

// ===== hw/rtl/pfla_checker.sv =====
// ----------------------------------------------------------------------------
// pfla_checker
// Port-level checks of the page free list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfla_checker import pfla_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a taken item keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous item in flight");

  // only a result with OK status may carry an address
  a_addr_only_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status != STAT_OK) |-> out_data.allocated_address == '0)
    else $error("address on a failed result");

  // an empty list reports a zero count
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == STAT_EMPTY) |-> out_data.free_count == '0)
    else $error("empty status with nonzero free count");

  // reset leaves no result and an open input
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind page_free_list_allocator_top pfla_checker u_pfla_checker (.*);
